// ===== src/rvcs_pkg.sv =====
// Shared types and decode constants for the RV32E subset core.
package rvcs_pkg;

    localparam logic [6:0] OPC_REG   = 7'b0110011;
    localparam logic [6:0] OPC_IMM   = 7'b0010011;
    localparam logic [6:0] OPC_LUI   = 7'b0110111;
    localparam logic [6:0] OPC_LOAD  = 7'b0000011;
    localparam logic [6:0] OPC_STORE = 7'b0100011;
    localparam logic [6:0] OPC_JALR  = 7'b1100111;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_JALR = 3'd0;
    localparam logic [6:0] F7_ADD  = 7'd0;

    localparam logic [31:0] UIMM_MASK  = 32'hFFFF_F000;
    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;
    localparam logic [7:0]  BYTE_MASK  = 8'hFF;

    localparam int OUT_W  = 120;  // 114 bits of fields padded to whole bytes
    localparam int MIDX_W = 10;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // What the second stage still has to do for an instruction
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ALU,
        KIND_LW,
        KIND_LBU,
        KIND_SW,
        KIND_SB
    } kind_t;

endpackage

// ===== src/rv32e_subset_core_step_top.sv =====
// Top level of the RV32E subset core: decode, execute, data memory and result register.
// A result word passes stage 1, stage 2 and the output register on its way to m_axis.
// Throughput: one instruction word per cycle unless m_axis stalls; the register file and
// data memory forward results of the two instructions ahead, so dependent instructions
// need no stall. Reset: synchronous active-low aresetn clears control and pc, then a pass
// over max(DATA_WORDS, 16) words zeroes data memory and register file, s_axis_tready low.
module rv32e_subset_core_step_top
    import rvcs_pkg::*;
#(
    parameter int DATA_WORDS = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [31:0] instruction
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // [1:0] status, [33:2] next_pc,
                                              // [34] reg_written, [38:35] reg_index,
                                              // [70:39] reg_value, [71] mem_written,
                                              // [81:72] mem_index, [113:82] mem_value
);

    localparam int AW        = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int CLR_WORDS = (DATA_WORDS > 16) ? DATA_WORDS : 16;
    localparam int CW        = $clog2(CLR_WORDS);

    // storage
    logic [31:0] rf_mem  [16];
    logic [31:0] dat_mem [DATA_WORDS];

    // clearing pass
    logic [CW-1:0] clr_cnt_reg;
    logic          clr_done_reg;
    logic          clr_rf_we;
    logic          clr_mem_we;

    // handshake
    logic adv;
    logic s_accept;

    // stage 1
    logic        s1_valid_reg;
    logic [31:0] s1_ins_reg;
    logic [31:0] rf_a_reg, rf_b_reg;
    logic        byp_a_hit_reg, byp_b_hit_reg;
    logic [31:0] byp_rf_data_reg;
    logic [31:0] pc_reg;

    // stage 2
    logic              s2_valid_reg;
    kind_t             s2_kind_reg;
    status_t           s2_status_reg;
    logic [31:0]       s2_pc_reg;
    logic [3:0]        s2_rd_reg;
    logic [31:0]       s2_val_reg;
    logic [1:0]        s2_lane_reg;
    logic [AW-1:0]     s2_widx_reg;
    logic [MIDX_W-1:0] s2_midx_reg;
    logic [31:0]       mem_raw_reg;
    logic              byp_mem_hit_reg;
    logic [31:0]       byp_mem_data_reg;

    // output
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    // stage 1 combinational
    logic [6:0]    op;
    logic [2:0]    f3;
    logic [6:0]    f7;
    logic [3:0]    rs1, rs2, rd;
    logic          is_add, is_addi, is_lui, is_lw, is_lbu, is_sw, is_sb, is_jalr;
    logic          legal, is_mem, in_range;
    logic [31:0]   imm, opa, opb, sum, pc4;
    kind_t         s2_kind_next;
    status_t       s2_status_next;
    logic [31:0]   s2_pc_next;
    logic [31:0]   s2_val_next;
    logic [AW-1:0] s1_widx;

    // stage 2 combinational
    logic [31:0]       mem_rd;
    logic [7:0]        ld_byte;
    logic [4:0]        lane_sh;
    logic              s2_reg_we;
    logic [31:0]       s2_reg_val;
    logic              s2_mem_we;
    logic [31:0]       s2_mem_val;
    logic [OUT_W-1:0]  out_data_next;

    // memory write ports
    logic          rf_we;
    logic [3:0]    rf_widx;
    logic [31:0]   rf_wdata;
    logic          mem_we;
    logic [AW-1:0] mem_widx;
    logic [31:0]   mem_wdata;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv && clr_done_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- clearing pass ----------------
    assign clr_rf_we  = !clr_done_reg && ({1'b0, clr_cnt_reg} < (CW+1)'(16));
    assign clr_mem_we = !clr_done_reg && ({1'b0, clr_cnt_reg} < (CW+1)'(DATA_WORDS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end else if (!clr_done_reg) begin
            if (clr_cnt_reg == CW'(CLR_WORDS - 1)) begin
                clr_done_reg <= 1'b1;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // ---------------- stage 1: decode and execute ----------------
    always_comb begin
        op  = s1_ins_reg[6:0];
        rd  = s1_ins_reg[10:7];
        f3  = s1_ins_reg[14:12];
        rs1 = s1_ins_reg[18:15];
        rs2 = s1_ins_reg[23:20];
        f7  = s1_ins_reg[31:25];

        is_add  = (op == OPC_REG) && (f3 == F3_ADD) && (f7 == F7_ADD);
        is_addi = (op == OPC_IMM) && (f3 == F3_ADD);
        is_lui  = (op == OPC_LUI);
        is_lw   = (op == OPC_LOAD) && (f3 == F3_LW);
        is_lbu  = (op == OPC_LOAD) && (f3 == F3_LBU);
        is_sw   = (op == OPC_STORE) && (f3 == F3_SW);
        is_sb   = (op == OPC_STORE) && (f3 == F3_SB);
        is_jalr = (op == OPC_JALR) && (f3 == F3_JALR);
        legal   = is_add || is_addi || is_lui || is_lw || is_lbu || is_sw || is_sb || is_jalr;
        is_mem  = is_lw || is_lbu || is_sw || is_sb;

        priority if (is_sw || is_sb) begin
            imm = {{20{s1_ins_reg[31]}}, s1_ins_reg[31:25], s1_ins_reg[11:7]};
        end else if (is_lui) begin
            imm = s1_ins_reg & UIMM_MASK;
        end else begin
            imm = {{20{s1_ins_reg[31]}}, s1_ins_reg[31:20]};
        end

        // forward from the instruction ahead, then from the write seen at the read edge
        priority if (s2_valid_reg && s2_reg_we && (s2_rd_reg == rs1)) begin
            opa = s2_reg_val;
        end else if (byp_a_hit_reg) begin
            opa = byp_rf_data_reg;
        end else begin
            opa = rf_a_reg;
        end
        priority if (s2_valid_reg && s2_reg_we && (s2_rd_reg == rs2)) begin
            opb = s2_reg_val;
        end else if (byp_b_hit_reg) begin
            opb = byp_rf_data_reg;
        end else begin
            opb = rf_b_reg;
        end

        sum      = opa + (is_add ? opb : imm);
        pc4      = pc_reg + 32'd4;
        in_range = (sum[31:2] < 30'(DATA_WORDS));
        s1_widx  = sum[AW+1:2];

        s2_status_next = ST_OK;
        s2_kind_next   = KIND_ALU;
        s2_val_next    = sum;
        priority if (!legal) begin
            s2_status_next = ST_ILLEGAL;
            s2_kind_next   = KIND_NONE;
        end else if (is_mem && !in_range) begin
            s2_status_next = ST_RANGE;
            s2_kind_next   = KIND_NONE;
        end else if (is_lw) begin
            s2_kind_next = KIND_LW;
        end else if (is_lbu) begin
            s2_kind_next = KIND_LBU;
        end else if (is_sw) begin
            s2_kind_next = KIND_SW;
            s2_val_next  = opb;
        end else if (is_sb) begin
            s2_kind_next = KIND_SB;
            s2_val_next  = opb;
        end else if (is_lui) begin
            s2_val_next = imm;
        end else if (is_jalr) begin
            s2_val_next = pc4;
        end else begin
            s2_val_next = sum;
        end

        if (s2_status_next != ST_OK) begin
            s2_pc_next = pc_reg;
        end else if (is_jalr) begin
            s2_pc_next = sum & ALIGN_MASK;
        end else begin
            s2_pc_next = pc4;
        end
    end

    // ---------------- stage 2: memory result and commit ----------------
    always_comb begin
        mem_rd  = byp_mem_hit_reg ? byp_mem_data_reg : mem_raw_reg;
        lane_sh = {s2_lane_reg, 3'b000};
        ld_byte = 8'(mem_rd >> lane_sh);

        s2_reg_we  = 1'b0;
        s2_reg_val = s2_val_reg;
        s2_mem_we  = 1'b0;
        s2_mem_val = s2_val_reg;
        unique case (s2_kind_reg)
            KIND_ALU: begin
                s2_reg_we = (s2_rd_reg != 4'd0);
            end
            KIND_LW: begin
                s2_reg_we  = (s2_rd_reg != 4'd0);
                s2_reg_val = mem_rd;
            end
            KIND_LBU: begin
                s2_reg_we  = (s2_rd_reg != 4'd0);
                s2_reg_val = {24'd0, ld_byte};
            end
            KIND_SW: begin
                s2_mem_we = 1'b1;
            end
            KIND_SB: begin
                s2_mem_we  = 1'b1;
                s2_mem_val = (mem_rd & ~({24'd0, BYTE_MASK} << lane_sh))
                           | ({24'd0, s2_val_reg[7:0]} << lane_sh);
            end
            default: begin
            end
        endcase

        out_data_next = '0;
        out_data_next[1:0]  = s2_status_reg;
        out_data_next[33:2] = s2_pc_reg;
        if (s2_reg_we) begin
            out_data_next[34]    = 1'b1;
            out_data_next[38:35] = s2_rd_reg;
            out_data_next[70:39] = s2_reg_val;
        end
        if (s2_mem_we) begin
            out_data_next[71]     = 1'b1;
            out_data_next[81:72]  = s2_midx_reg;
            out_data_next[113:82] = s2_mem_val;
        end
    end

    // write ports shared between the clearing pass and commit
    always_comb begin
        if (!clr_done_reg) begin
            rf_we     = clr_rf_we;
            rf_widx   = clr_cnt_reg[3:0];
            rf_wdata  = '0;
            mem_we    = clr_mem_we;
            mem_widx  = clr_cnt_reg[AW-1:0];
            mem_wdata = '0;
        end else begin
            rf_we     = adv && s2_valid_reg && s2_reg_we;
            rf_widx   = s2_rd_reg;
            rf_wdata  = s2_reg_val;
            mem_we    = adv && s2_valid_reg && s2_mem_we;
            mem_widx  = s2_widx_reg;
            mem_wdata = s2_mem_val;
        end
    end

    // ---------------- storage ----------------
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_widx] <= rf_wdata;
        end
        if (s_accept) begin
            rf_a_reg        <= rf_mem[s_axis_tdata[18:15]];
            rf_b_reg        <= rf_mem[s_axis_tdata[23:20]];
            byp_a_hit_reg   <= rf_we && (rf_widx == s_axis_tdata[18:15]);
            byp_b_hit_reg   <= rf_we && (rf_widx == s_axis_tdata[23:20]);
            byp_rf_data_reg <= rf_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dat_mem[mem_widx] <= mem_wdata;
        end
        if (adv) begin
            mem_raw_reg      <= dat_mem[s1_widx];
            byp_mem_hit_reg  <= mem_we && (mem_widx == s1_widx);
            byp_mem_data_reg <= mem_wdata;
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end else if (adv) begin
            s1_valid_reg  <= s_accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s1_valid_reg) begin
                pc_reg <= s2_pc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ins_reg <= s_axis_tdata;
        end
        if (adv) begin
            s2_kind_reg   <= s2_kind_next;
            s2_status_reg <= s2_status_next;
            s2_pc_reg     <= s2_pc_next;
            s2_rd_reg     <= rd;
            s2_val_reg    <= s2_val_next;
            s2_lane_reg   <= sum[1:0];
            s2_widx_reg   <= s1_widx;
            s2_midx_reg   <= sum[MIDX_W+1:2];
            out_data_reg  <= out_data_next;
        end
    end

endmodule

// ===== src/rvcs_checker.sv =====
// Port-level checks for the RV32E subset core, bound to its top level.
module rvcs_checker
    import rvcs_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // no word is taken right after reset while memory is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    // an error result commits nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK)
        |-> !m_axis_tdata[34] && !m_axis_tdata[71] && (m_axis_tdata[113:35] == '0))
        else $error("error result carries a write");

    // register 0 is never reported written, and an instruction writes at most one target
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[34] == (m_axis_tdata[38:35] != 4'd0))
                          && !(m_axis_tdata[34] && m_axis_tdata[71]))
        else $error("bad register write report");

endmodule

bind rv32e_subset_core_step_top rvcs_checker u_rvcs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/core_retire_pkg.sv =====
// Scoreboard class that predicts and checks each result word of the RV32E subset core.
package core_retire_pkg;
    import rvcs_pkg::*;

    localparam int CORE_DATA_WORDS = 1024;

    typedef struct {
        status_t           status;
        logic [31:0]       next_pc;
        logic              reg_written;
        logic [3:0]        reg_index;
        logic [31:0]       reg_value;
        logic              mem_written;
        logic [MIDX_W-1:0] mem_index;
        logic [31:0]       mem_value;
    } retire_t;

    class core_retire_model;
        logic [31:0] regs [16];
        logic [31:0] pc;
        logic [31:0] dmem [CORE_DATA_WORDS];
        retire_t     pending_retires [$];
        int          failures;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            pc = '0;
            failures = 0;
        endfunction

        // Execute one accepted instruction word on the shadow state and queue its result.
        function void note_issued(logic [31:0] ins);
            logic [6:0]  opc;
            logic [6:0]  f7;
            logic [2:0]  f3;
            logic [3:0]  rd;
            logic [3:0]  rs1;
            logic [3:0]  rs2;
            logic [31:0] imm;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] sum;
            logic [31:0] wval;
            logic [31:0] new_word;
            logic [31:0] widx;
            int          sh;
            bit          is_add, is_addi, is_lui, is_lw, is_lbu, is_sw, is_sb, is_jalr;
            bit          wreg;
            retire_t     r;

            opc = ins[6:0];
            rd  = ins[10:7];
            f3  = ins[14:12];
            rs1 = ins[18:15];
            rs2 = ins[23:20];
            f7  = ins[31:25];
            is_add  = (opc == OPC_REG) && (f3 == F3_ADD) && (f7 == F7_ADD);
            is_addi = (opc == OPC_IMM) && (f3 == F3_ADD);
            is_lui  = (opc == OPC_LUI);
            is_lw   = (opc == OPC_LOAD) && (f3 == F3_LW);
            is_lbu  = (opc == OPC_LOAD) && (f3 == F3_LBU);
            is_sw   = (opc == OPC_STORE) && (f3 == F3_SW);
            is_sb   = (opc == OPC_STORE) && (f3 == F3_SB);
            is_jalr = (opc == OPC_JALR) && (f3 == F3_JALR);

            r.status      = ST_OK;
            r.next_pc     = pc;
            r.reg_written = 1'b0;
            r.reg_index   = '0;
            r.reg_value   = '0;
            r.mem_written = 1'b0;
            r.mem_index   = '0;
            r.mem_value   = '0;
            wreg = 1'b0;
            wval = '0;
            imm  = '0;

            if (!(is_add || is_addi || is_lui || is_lw || is_lbu || is_sw || is_sb || is_jalr)) begin
                r.status = ST_ILLEGAL;
                pending_retires.push_back(r);
                return;
            end

            if (is_addi || is_lw || is_lbu || is_jalr)
                imm = {{20{ins[31]}}, ins[31:20]};
            else if (is_sw || is_sb)
                imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            else if (is_lui)
                imm = ins & UIMM_MASK;

            a = regs[rs1];
            b = regs[rs2];
            sum = a + (is_add ? b : imm);

            if (is_lw || is_lbu || is_sw || is_sb) begin
                widx = sum >> 2;
                sh = int'(sum[1:0]) * 8;
                // out-of-range access leaves every piece of state alone
                if (widx >= CORE_DATA_WORDS) begin
                    r.status = ST_RANGE;
                    pending_retires.push_back(r);
                    return;
                end
                if (is_sw || is_sb) begin
                    if (is_sw)
                        new_word = b;
                    else
                        new_word = (dmem[widx] & ~(32'(BYTE_MASK) << sh))
                                 | ((b & 32'(BYTE_MASK)) << sh);
                    dmem[widx] = new_word;
                    r.mem_written = 1'b1;
                    r.mem_index   = widx[MIDX_W-1:0];
                    r.mem_value   = new_word;
                end else begin
                    wreg = 1'b1;
                    wval = is_lw ? dmem[widx] : ((dmem[widx] >> sh) & 32'(BYTE_MASK));
                end
            end else begin
                wreg = 1'b1;
                wval = is_lui ? imm : (is_jalr ? pc + 32'd4 : sum);
            end

            if (wreg && rd != 4'd0) begin
                regs[rd] = wval;
                r.reg_written = 1'b1;
                r.reg_index   = rd;
                r.reg_value   = wval;
            end

            pc = is_jalr ? (sum & ALIGN_MASK) : pc + 32'd4;
            r.next_pc = pc;
            pending_retires.push_back(r);
        endfunction

        function void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
                failures++;
            end
        endfunction

        // Compare one accepted result word against the oldest prediction.
        function void check_retired(logic [OUT_W-1:0] word);
            retire_t r;
            if (pending_retires.size() == 0) begin
                $display("%0t: result word with nothing pending, expected none, actual %h",
                         $time, word);
                failures++;
                return;
            end
            r = pending_retires.pop_front();
            cmp_field("status",      32'(r.status),      32'(word[1:0]));
            cmp_field("next_pc",     r.next_pc,          word[33:2]);
            cmp_field("reg_written", 32'(r.reg_written), 32'(word[34]));
            cmp_field("reg_index",   32'(r.reg_index),   32'(word[38:35]));
            cmp_field("reg_value",   r.reg_value,        word[70:39]);
            cmp_field("mem_written", 32'(r.mem_written), 32'(word[71]));
            cmp_field("mem_index",   32'(r.mem_index),   32'(word[81:72]));
            cmp_field("mem_value",   r.mem_value,        word[113:82]);
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
// Testbench top: drives instruction words into the RV32E subset core and checks each result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rvcs_pkg::*;
    import core_retire_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 850;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 8;
    localparam logic [2:0] F3_BAD = 3'd1;
    localparam logic [6:0] F7_BAD = 7'h20;

    typedef enum int {
        GEN_ADD, GEN_ADDI, GEN_LUI, GEN_LW, GEN_LBU, GEN_SW, GEN_SB, GEN_JALR
    } gen_op_t;

    logic             aclk;
    logic             aresetn;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    core_retire_model sb;
    bit gaps_on;
    bit stall_on;
    bit hold_req;
    int hold_left;
    int idle_cycles;

    rv32e_subset_core_step_top #(
        .DATA_WORDS(CORE_DATA_WORDS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
        return {imm, rd, OPC_LUI};
    endfunction

    // Build a legal instruction; most memory ops aim at an address through the predicted registers.
    function automatic logic [31:0] gen_legal();
        gen_op_t     op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [11:0] imm;
        logic [31:0] target;
        longint      d;
        int          sel;
        int          start;
        int          r;
        op  = gen_op_t'($urandom_range(0, 7));
        rd  = 5'($urandom_range(0, 31));
        rs1 = 5'($urandom_range(0, 31));
        rs2 = 5'($urandom_range(0, 31));
        imm = 12'($urandom_range(0, 4095));
        if (op == GEN_LW || op == GEN_LBU || op == GEN_SW || op == GEN_SB) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                if (sel < 40)
                    target = $urandom_range(0, 63);
                else if (sel < 70)
                    target = $urandom_range(0, CORE_DATA_WORDS * 4 - 1);
                else
                    target = CORE_DATA_WORDS * 4 - 8 + $urandom_range(0, 15);
                start = $urandom_range(0, 15);
                for (int i = 0; i < 16; i++) begin
                    r = (start + i) % 16;
                    d = longint'(target) - longint'(sb.regs[r]);
                    if (d >= -2048 && d <= 2047) begin
                        rs1 = {1'($urandom_range(0, 1)), 4'(r)};
                        imm = d[11:0];
                        break;
                    end
                end
            end
        end
        case (op)
            GEN_ADD:  return enc_r(F7_ADD, rs2, rs1, F3_ADD, rd, OPC_REG);
            GEN_ADDI: return enc_i(imm, rs1, F3_ADD, rd, OPC_IMM);
            GEN_LUI:  return enc_u(20'($urandom), rd);
            GEN_LW:   return enc_i(imm, rs1, F3_LW, rd, OPC_LOAD);
            GEN_LBU:  return enc_i(imm, rs1, F3_LBU, rd, OPC_LOAD);
            GEN_SW:   return enc_s(imm, rs2, rs1, F3_SW);
            GEN_SB:   return enc_s(imm, rs2, rs1, F3_SB);
            default:  return enc_i(imm, rs1, F3_JALR, rd, OPC_JALR);
        endcase
    endfunction

    // Enter and leave at a falling edge; hold the word until it is taken.
    task automatic drive_instr(input logic [31:0] ins);
        if (gaps_on && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge aclk); while (gaps_on && $urandom_range(0, 99) < 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ins;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending_retires.size() != 0);
    endtask

    // Observe both handshakes at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_issued(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_retired(m_axis_tdata);
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        hold_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_on && $urandom_range(0, 99) < 30) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int          sent;
        int          roll;
        int          n;
        bit          hold_done;
        bit          pause_done;
        logic [31:0] ins;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        gaps_on    = 1'b1;
        stall_on   = 1'b1;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        sb = new();
        aresetn = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes of the immediates, rd of zero, byte lanes, misaligned words
        drive_instr(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd1, OPC_IMM));
        drive_instr(enc_i(12'h800, 5'd0, F3_ADD, 5'd2, OPC_IMM));
        drive_instr(enc_r(F7_ADD, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_REG));
        drive_instr(enc_u(20'hFFFFF, 5'd4));
        drive_instr(enc_r(F7_ADD, 5'd1, 5'd1, F3_ADD, 5'd0, OPC_REG));
        drive_instr(enc_s(12'd0, 5'd1, 5'd0, F3_SW));
        drive_instr(enc_s(12'd1, 5'd3, 5'd0, F3_SB));
        drive_instr(enc_s(12'd7, 5'd1, 5'd0, F3_SB));
        drive_instr(enc_i(12'd0, 5'd0, F3_LW, 5'd5, OPC_LOAD));
        drive_instr(enc_i(12'd1, 5'd0, F3_LBU, 5'd6, OPC_LOAD));
        drive_instr(enc_i(12'd7, 5'd0, F3_LBU, 5'd7, OPC_LOAD));
        drive_instr(enc_i(12'd3, 5'd0, F3_LW, 5'd8, OPC_LOAD));
        drive_instr(enc_s(12'd6, 5'd3, 5'd0, F3_SW));
        // last word in range, first word past it, and a wrapped negative address
        drive_instr(enc_u(20'd1, 5'd9));
        drive_instr(enc_i(12'hFFC, 5'd9, F3_LW, 5'd10, OPC_LOAD));
        drive_instr(enc_s(12'd0, 5'd10, 5'd9, F3_SW));
        drive_instr(enc_i(12'd0, 5'd2, F3_LBU, 5'd11, OPC_LOAD));
        // illegal encodings
        drive_instr(32'hFFFF_FFFF);
        drive_instr(32'h0000_0000);
        drive_instr(enc_r(F7_BAD, 5'd1, 5'd1, F3_ADD, 5'd12, OPC_REG));
        drive_instr(enc_i(12'd1, 5'd1, F3_BAD, 5'd12, OPC_IMM));
        drive_instr(enc_i(12'd0, 5'd1, F3_BAD, 5'd12, OPC_JALR));
        // index bit 4 is dropped; store offset keeps bit 4 of imm[4:0]
        drive_instr(enc_r(F7_ADD, 5'd17, 5'd19, F3_ADD, 5'd28, OPC_REG));
        drive_instr(enc_s(12'd16, 5'd1, 5'd16, F3_SW));
        // jalr with low address bits set, then a jump to the top of the space and wrap
        drive_instr(enc_i(12'd6, 5'd1, F3_JALR, 5'd13, OPC_JALR));
        drive_instr(enc_i(12'hFFF, 5'd3, F3_JALR, 5'd0, OPC_JALR));
        drive_instr(enc_i(12'd1, 5'd0, F3_ADD, 5'd14, OPC_IMM));
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            gaps_on  = !(sent >= 300 && sent < 480);
            stall_on = gaps_on;
            if (!hold_done && sent >= 150) begin
                hold_done = 1'b1;
                hold_req = 1'b1;
            end
            if (!pause_done && sent >= 600) begin
                pause_done = 1'b1;
                wait_drained();
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                // sometimes set up a base register, then a burst of legal work
                if ($urandom_range(0, 1) == 1) begin
                    drive_instr(enc_i(12'($urandom_range(0, 2047)), 5'd0, F3_ADD,
                                      5'($urandom_range(1, 15)), OPC_IMM));
                    sent++;
                end
                n = $urandom_range(1, 8);
                repeat (n) begin
                    drive_instr(gen_legal());
                    sent++;
                end
            end else if (roll < 85) begin
                drive_instr($urandom);
                sent++;
            end else begin
                ins = gen_legal();
                if ($urandom_range(0, 1) == 1)
                    ins[14:12] = 3'($urandom);
                else
                    ins = ins ^ (32'd1 << $urandom_range(0, 31));
                drive_instr(ins);
                sent++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
